// ===== src/plc_pkg.sv =====
// plc_pkg: shared types, constants and a helper function for the positional list engine.
// Standalone package with no dependencies. The interfaces and all plc_* modules use it.
`timescale 1ns / 1ps

package plc_pkg;

  // Field widths of the transaction payloads
  localparam int OPCODE_W   = 3;
  localparam int POSITION_W = 7;
  localparam int ELEM_IN_W  = 32;
  localparam int ELEM_OUT_W = 32;
  localparam int SIZE_W     = 7;
  localparam int GRANULE_W  = 7;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF        = 64;
  localparam int ELEMENT_BITS_DEF = 32;

  localparam logic [GRANULE_W-1:0] GRANULE_RESET = 7'd1;

  // Operation codes
  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_INSERT    = 3'd1,
    OP_PEEK      = 3'd2,
    OP_REMOVE    = 3'd3,
    OP_EXTRACT   = 3'd4,
    OP_OVERWRITE = 3'd5
  } plc_op_e;

  // Per-cell action broadcast along the row
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_INS   = 2'd1,   // shift up above pos, write at pos
    ACT_DEL   = 2'd2,   // shift down from pos
    ACT_WR    = 2'd3    // write at pos only
  } plc_act_e;

  typedef struct packed {
    logic     en;       // transaction accepted this cycle
    plc_act_e act;
  } plc_cmd_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_GATHER = 2'd1,
    ST_DONE   = 2'd2
  } plc_state_e;

  // Group size of the read tree: smallest g with g*g >= depth
  function automatic int grp_size(input int depth);
    int g;
    g = 1;
    while (g * g < depth) g = g + 1;
    return g;
  endfunction

endpackage

// ===== src/plc_if.sv =====
// plc_if: valid/ready stream interfaces for the list engine's input and result channels.
// Depends on plc_pkg for field widths.
`timescale 1ns / 1ps

interface plc_in_if;
  logic                               valid;
  logic                               ready;
  logic [plc_pkg::OPCODE_W-1:0]       opcode;
  logic [plc_pkg::POSITION_W-1:0]     position;
  logic [plc_pkg::ELEM_IN_W-1:0]      element_in;

  modport source (output valid, opcode, position, element_in, input ready);
  modport sink   (input valid, opcode, position, element_in, output ready);
endinterface

interface plc_out_if;
  logic                               valid;
  logic                               ready;
  logic                               ok;
  logic [plc_pkg::ELEM_OUT_W-1:0]     element_out;
  logic [plc_pkg::SIZE_W-1:0]         list_size;
  logic [plc_pkg::SIZE_W-1:0]         reserved;

  modport source (output valid, ok, element_out, list_size, reserved, input ready);
  modport sink   (input valid, ok, element_out, list_size, reserved, output ready);
endinterface

// ===== src/plc_cell.sv =====
// plc_cell: one storage cell of the list row; holds one element and trades it with neighbors.
// Depends on plc_pkg for the command struct.
`timescale 1ns / 1ps

module plc_cell #(
  parameter int EW    = plc_pkg::ELEMENT_BITS_DEF,
  parameter int CMP_W = 8,
  parameter int INDEX = 0
) (
  input  logic                clk,
  input  plc_pkg::plc_cmd_t   cmd,
  input  logic [CMP_W-1:0]    pos,
  input  logic [EW-1:0]       val_in,
  input  logic [EW-1:0]       left_in,    // element of the cell below
  input  logic [EW-1:0]       right_in,   // element of the cell above
  output logic [EW-1:0]       data_out,
  output logic [EW-1:0]       rd_out      // own element if addressed, else zero
);

  localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

  logic [EW-1:0] data_r;
  logic [EW-1:0] data_nxt;
  logic [EW-1:0] rd_r;
  logic          hit;
  logic          above;

  assign hit   = (IDX == pos);
  assign above = (IDX > pos);

  // Next element for this cell
  always_comb begin
    data_nxt = data_r;
    case (cmd.act)
      plc_pkg::ACT_INS: begin
        if (above) data_nxt = left_in;
        else if (hit) data_nxt = val_in;
      end
      plc_pkg::ACT_DEL: begin
        if (above || hit) data_nxt = right_in;
      end
      plc_pkg::ACT_WR: begin
        if (hit) data_nxt = val_in;
      end
      default: data_nxt = data_r;
    endcase
  end

  // Element store and read capture (old value, before the update)
  always_ff @(posedge clk) begin
    if (cmd.en) begin
      data_r <= data_nxt;
      rd_r   <= hit ? data_r : '0;
    end
  end

  assign data_out = data_r;
  assign rd_out   = rd_r;

endmodule

// ===== src/plc_rd_tree.sv =====
// plc_rd_tree: two-level OR tree that collects the one addressed cell's read value.
// Depends on plc_pkg for the group-size function.
`timescale 1ns / 1ps

module plc_rd_tree #(
  parameter int EW    = plc_pkg::ELEMENT_BITS_DEF,
  parameter int DEPTH = plc_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          load,
  input  logic [EW-1:0] leaf [DEPTH],
  output logic [EW-1:0] rd_out
);

  localparam int G  = plc_pkg::grp_size(DEPTH);
  localparam int NG = (DEPTH + G - 1) / G;

  logic [EW-1:0] pad [NG*G];
  logic [EW-1:0] grp_or [NG];
  logic [EW-1:0] grp_r [NG];

  // Pad the leaves up to a whole number of groups
  for (genvar i = 0; i < NG * G; i++) begin : g_pad
    if (i < DEPTH) begin : g_real
      assign pad[i] = leaf[i];
    end else begin : g_zero
      assign pad[i] = '0;
    end
  end

  // First level: OR within each group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_or[g] = '0;
      for (int k = 0; k < G; k++) grp_or[g] = grp_or[g] | pad[g*G + k];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < NG; g++) grp_r[g] <= grp_or[g];
    end
  end

  // Second level: OR across the group registers
  always_comb begin
    rd_out = '0;
    for (int g = 0; g < NG; g++) rd_out = rd_out | grp_r[g];
  end

endmodule

// ===== src/positional_list_engine_core.sv =====
// positional_list_engine_core: top level; decode, cell row, read tree, result register, APB.
// Depends on plc_pkg, plc_if, plc_cell and plc_rd_tree.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+------------------------------------------
//  in_ch   | in        | valid/ready      | opcode, position, element_in
//  out_ch  | out       | valid/ready      | ok, element_out, list_size, reserved
//  cfg_*   | in        | APB, pready = 1  | granule at byte address 0
//
// In each transaction the cell row updates and captures the addressed element at the
// accepting edge, the first OR level of the read tree registers next, and the result
// register loads after that. in_ch.ready is high only while the sequencer is idle.
// A held result in the output register does not block the next accept; the sequencer
// waits in its last state only when a second result is ready and the first is still held.
// rst_n is synchronous; reset clears size, reserved capacity and control state, and sets the granule to GRANULE_RESET.
`timescale 1ns / 1ps

module positional_list_engine_core #(
  parameter int DEPTH        = plc_pkg::DEPTH_DEF,
  parameter int ELEMENT_BITS = plc_pkg::ELEMENT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  plc_in_if.sink                           in_ch,
  plc_out_if.source                        out_ch,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [plc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [plc_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [plc_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);

  localparam int EW    = ELEMENT_BITS;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int BASEW = (CNT_W > plc_pkg::POSITION_W) ? CNT_W : plc_pkg::POSITION_W;
  localparam int CMP_W = BASEW + 1;
  localparam int XW    = (EW > plc_pkg::ELEM_OUT_W) ? EW : plc_pkg::ELEM_OUT_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

  // ---------------- configuration register ----------------
  logic [plc_pkg::GRANULE_W-1:0] granule_r;
  logic                          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? plc_pkg::CFG_DATA_W'(granule_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      granule_r <= plc_pkg::GRANULE_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == 1'b0)) begin
      granule_r <= cfg_pwdata[plc_pkg::GRANULE_W-1:0];
    end
  end

  // ---------------- state ----------------
  plc_pkg::plc_state_e state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    cap_r, cap_nxt;
  logic                ok_r;
  logic                rdsel_r;

  logic                in_acc;
  logic                out_load;

  assign in_acc = in_ch.valid && in_ch.ready;

  // ---------------- operation decode ----------------
  logic [CMP_W-1:0]    pos_c, cnt_c, cap_c, gran_c, grown_c;
  logic                not_full, need_grow, grow_ok, room_ok, in_range;
  logic                ok_c, rdsel_c;
  plc_pkg::plc_act_e   act_c;
  logic [CMP_W-1:0]    cmd_pos;
  plc_pkg::plc_op_e    op_c;

  assign op_c      = plc_pkg::plc_op_e'(in_ch.opcode);
  assign pos_c     = CMP_W'(in_ch.position);
  assign cnt_c     = CMP_W'(count_r);
  assign cap_c     = CMP_W'(cap_r);
  assign gran_c    = (granule_r == '0) ? CMP_W'(1) : CMP_W'(granule_r);
  assign grown_c   = cap_c + gran_c;
  assign not_full  = cnt_c < DEPTH_C;
  assign need_grow = cnt_c >= cap_c;
  assign grow_ok   = grown_c <= DEPTH_C;
  assign room_ok   = !need_grow || grow_ok;
  assign in_range  = pos_c < cnt_c;

  always_comb begin
    ok_c    = 1'b0;
    rdsel_c = 1'b0;
    act_c   = plc_pkg::ACT_NONE;
    cmd_pos = pos_c;
    case (op_c)
      plc_pkg::OP_APPEND: begin
        ok_c    = not_full && room_ok;
        act_c   = plc_pkg::ACT_INS;
        cmd_pos = cnt_c;
      end
      plc_pkg::OP_INSERT: begin
        ok_c  = (pos_c <= cnt_c) && not_full && room_ok;
        act_c = plc_pkg::ACT_INS;
      end
      plc_pkg::OP_PEEK: begin
        ok_c    = in_range;
        rdsel_c = 1'b1;
      end
      plc_pkg::OP_REMOVE: begin
        ok_c  = in_range;
        act_c = plc_pkg::ACT_DEL;
      end
      plc_pkg::OP_EXTRACT: begin
        ok_c    = in_range;
        rdsel_c = 1'b1;
        act_c   = plc_pkg::ACT_DEL;
      end
      plc_pkg::OP_OVERWRITE: begin
        ok_c  = in_range;
        act_c = plc_pkg::ACT_WR;
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase
    if (!ok_c) act_c = plc_pkg::ACT_NONE;
  end

  // Size and reserved capacity after the operation
  always_comb begin
    count_nxt = count_r;
    cap_nxt   = cap_r;
    if (in_acc && ok_c) begin
      case (act_c)
        plc_pkg::ACT_INS: begin
          count_nxt = count_r + CNT_W'(1);
          if (need_grow) cap_nxt = grown_c[CNT_W-1:0];
        end
        plc_pkg::ACT_DEL: count_nxt = count_r - CNT_W'(1);
        default:          count_nxt = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= '0;
      ok_r    <= 1'b0;
      rdsel_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      cap_r   <= cap_nxt;
      if (in_acc) begin
        ok_r    <= ok_c;
        rdsel_r <= rdsel_c && ok_c;
      end
    end
  end

  // ---------------- cell row ----------------
  plc_pkg::plc_cmd_t cmd;
  logic [EW-1:0]     val_c;
  logic [EW-1:0]     data_w [DEPTH];
  logic [EW-1:0]     rd_w   [DEPTH];

  assign cmd.en  = in_acc;
  assign cmd.act = act_c;
  assign val_c   = EW'(in_ch.element_in);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [EW-1:0] left_c;
    logic [EW-1:0] right_c;
    if (i == 0) begin : g_first
      assign left_c = '0;
    end else begin : g_mid_l
      assign left_c = data_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_c = data_w[i];
    end else begin : g_mid_r
      assign right_c = data_w[i+1];
    end
    plc_cell #(
      .EW    (EW),
      .CMP_W (CMP_W),
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .pos      (cmd_pos),
      .val_in   (val_c),
      .left_in  (left_c),
      .right_in (right_c),
      .data_out (data_w[i]),
      .rd_out   (rd_w[i])
    );
  end

  // ---------------- read tree ----------------
  logic [EW-1:0] rd_val;

  plc_rd_tree #(
    .EW    (EW),
    .DEPTH (DEPTH)
  ) u_rd_tree (
    .clk    (clk),
    .load   (state_r == plc_pkg::ST_GATHER),
    .leaf   (rd_w),
    .rd_out (rd_val)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plc_pkg::ST_IDLE:   if (in_acc) state_nxt = plc_pkg::ST_GATHER;
      plc_pkg::ST_GATHER: state_nxt = plc_pkg::ST_DONE;
      plc_pkg::ST_DONE:   if (out_load) state_nxt = plc_pkg::ST_IDLE;
      default:            state_nxt = plc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      plc_pkg::ST_IDLE: in_ch.ready = 1'b1;
      plc_pkg::ST_DONE: out_load = !out_ch.valid || out_ch.ready;
      default: begin
        in_ch.ready = 1'b0;
        out_load    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= plc_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // ---------------- result register ----------------
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_ok_r;
  logic [plc_pkg::ELEM_OUT_W-1:0] out_elem_r;
  logic [plc_pkg::SIZE_W-1:0]     out_size_r;
  logic [plc_pkg::SIZE_W-1:0]     out_resv_r;
  logic [XW-1:0]                  rd_ext;

  assign rd_ext = XW'(rd_val);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load)          out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok_r   <= ok_r;
      out_elem_r <= rdsel_r ? rd_ext[plc_pkg::ELEM_OUT_W-1:0] : '0;
      out_size_r <= plc_pkg::SIZE_W'(count_r);
      out_resv_r <= plc_pkg::SIZE_W'(cap_r);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.ok          = out_ok_r;
  assign out_ch.element_out = out_elem_r;
  assign out_ch.list_size   = out_size_r;
  assign out_ch.reserved    = out_resv_r;

  // ---------------- assertions ----------------
  a_size_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r) else $error("list size exceeds reserved capacity");

  a_cap_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(cap_r) <= DEPTH_C) else $error("reserved capacity exceeds depth");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !ok_c) |=> ($stable(count_r) && $stable(cap_r)))
    else $error("rejected transaction changed list state");

  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == plc_pkg::ST_GATHER))
    else $error("sequencer did not start after accept");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == plc_pkg::ST_DONE))
    else $error("result raised outside of completion state");

endmodule

// ===== tb/sv/positional_list_engine_core_tb.sv =====
// positional_list_engine_core_tb: self-checking bench for the positional list engine.
// Depends on plc_pkg, plc_if and the positional_list_engine_core RTL; drives both
// streams and the APB port, and checks every result against a local list predictor or a typed-in expectation.
`timescale 1ns / 1ps

module positional_list_engine_core_tb;

  localparam int LIST_DEPTH   = plc_pkg::DEPTH_DEF;
  localparam int N_DIRECTED   = 22;
  localparam int N_PHASES     = 10;
  localparam int PHASE_ITEMS  = 190;
  localparam int HOLD_AT      = 600;   // result index at which the sink stalls for long
  localparam int HOLD_CYCLES  = 300;

  // Opcodes outside the defined set
  localparam logic [plc_pkg::OPCODE_W-1:0] OP_UNDEF_LO = 3'd6;
  localparam logic [plc_pkg::OPCODE_W-1:0] OP_UNDEF_HI = 3'd7;

  localparam logic [plc_pkg::CFG_ADDR_W-1:0] GRANULE_ADDR = 3'd0;

  typedef struct packed {
    logic [plc_pkg::OPCODE_W-1:0]   opcode;
    logic [plc_pkg::POSITION_W-1:0] position;
    logic [plc_pkg::ELEM_IN_W-1:0]  element_in;
  } list_op_t;

  typedef struct packed {
    logic                           ok;
    logic [plc_pkg::ELEM_OUT_W-1:0] element_out;
    logic [plc_pkg::SIZE_W-1:0]     list_size;
    logic [plc_pkg::SIZE_W-1:0]     reserved;
  } list_result_t;

  typedef struct packed {
    list_op_t     op;
    logic         fixed;   // expected result typed in below
    list_result_t res;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [plc_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [plc_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [plc_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  plc_in_if  list_in_if ();
  plc_out_if list_out_if ();

  positional_list_engine_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (list_in_if),
    .out_ch      (list_out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted list contents, occupancy and reserved capacity
  logic [plc_pkg::ELEM_IN_W-1:0] model_entries [LIST_DEPTH];
  int unsigned                   model_count;
  int unsigned                   model_cap;
  logic [plc_pkg::GRANULE_W-1:0] model_granule;

  list_result_t  pending_results [$];
  list_result_t  oldest_result;
  int            mismatch_count;
  bit            no_idle;
  directed_row_t directed_rows [N_DIRECTED];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Grow reserved capacity by one granule when the list is at capacity
  function automatic bit reserve_slot();
    int unsigned step;
    step = (model_granule == '0) ? 1 : int'(model_granule);
    if (model_count + 1 <= model_cap) return 1'b1;
    if (model_cap + step > LIST_DEPTH) return 1'b0;
    model_cap += step;
    return 1'b1;
  endfunction

  function automatic void close_gap(input int unsigned pos);
    for (int unsigned i = pos; i + 1 < model_count; i++)
      model_entries[i] = model_entries[i + 1];
    model_count--;
  endfunction

  // Apply one operation to the predicted list and return its result
  function automatic list_result_t apply_list_op(input list_op_t op);
    list_result_t r;
    int unsigned  pos;
    r   = '0;
    pos = op.position;
    case (op.opcode)
      plc_pkg::OP_APPEND: begin
        if (model_count < LIST_DEPTH) begin
          if (reserve_slot()) begin
            model_entries[model_count] = op.element_in;
            model_count++;
            r.ok = 1'b1;
          end
        end
      end
      plc_pkg::OP_INSERT: begin
        if (pos <= model_count && model_count < LIST_DEPTH) begin
          if (reserve_slot()) begin
            for (int unsigned i = model_count; i > pos; i--)
              model_entries[i] = model_entries[i - 1];
            model_entries[pos] = op.element_in;
            model_count++;
            r.ok = 1'b1;
          end
        end
      end
      plc_pkg::OP_PEEK: begin
        if (pos < model_count) begin
          r.element_out = model_entries[pos];
          r.ok = 1'b1;
        end
      end
      plc_pkg::OP_REMOVE: begin
        if (pos < model_count) begin
          close_gap(pos);
          r.ok = 1'b1;
        end
      end
      plc_pkg::OP_EXTRACT: begin
        if (pos < model_count) begin
          r.element_out = model_entries[pos];
          close_gap(pos);
          r.ok = 1'b1;
        end
      end
      plc_pkg::OP_OVERWRITE: begin
        if (pos < model_count) begin
          model_entries[pos] = op.element_in;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.list_size = plc_pkg::SIZE_W'(model_count);
    r.reserved  = plc_pkg::SIZE_W'(model_cap);
    return r;
  endfunction

  // Random operation; mostly legal positions for the current predicted size
  function automatic list_op_t draw_list_op(input int grow_pct);
    list_op_t op;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      op.opcode = ($urandom_range(0, 1) != 0) ? OP_UNDEF_HI : OP_UNDEF_LO;
    end else if (r < 3 + grow_pct) begin
      op.opcode = ($urandom_range(0, 1) != 0) ? plc_pkg::OP_INSERT : plc_pkg::OP_APPEND;
    end else begin
      case ($urandom_range(0, 3))
        0:       op.opcode = plc_pkg::OP_PEEK;
        1:       op.opcode = plc_pkg::OP_REMOVE;
        2:       op.opcode = plc_pkg::OP_EXTRACT;
        default: op.opcode = plc_pkg::OP_OVERWRITE;
      endcase
    end
    if ($urandom_range(0, 9) == 0)
      op.position = plc_pkg::POSITION_W'($urandom_range(0, 127));
    else if (op.opcode == plc_pkg::OP_INSERT)
      op.position = plc_pkg::POSITION_W'($urandom_range(0, model_count));
    else if (model_count > 0)
      op.position = plc_pkg::POSITION_W'($urandom_range(0, model_count - 1));
    else
      op.position = plc_pkg::POSITION_W'($urandom_range(0, 127));
    case ($urandom_range(0, 9))
      0:       op.element_in = '0;
      1:       op.element_in = '1;
      default: op.element_in = $urandom;
    endcase
    return op;
  endfunction

  // Offer one transaction; the expectation is queued at the accepting edge
  task automatic send_list_op(input list_op_t op, input logic fixed,
                              input list_result_t fixed_res);
    int           gap;
    list_result_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      list_in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    list_in_if.valid      <= 1'b1;
    list_in_if.opcode     <= op.opcode;
    list_in_if.position   <= op.position;
    list_in_if.element_in <= op.element_in;
    do @(posedge clk); while (!list_in_if.ready);
    predicted = apply_list_op(op);
    pending_results.push_back(fixed ? fixed_res : predicted);
  endtask

  // APB write of the granule register, then read it back; only while idle
  task automatic set_granule(input logic [plc_pkg::GRANULE_W-1:0] value);
    list_in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= GRANULE_ADDR;
    cfg_pwdata  <= plc_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    model_granule = value;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== plc_pkg::CFG_DATA_W'(value))
      report_mismatch("granule readback", cfg_prdata, plc_pkg::CFG_DATA_W'(value));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Result checker: every accepted transaction against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && list_out_if.valid && list_out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", list_out_if.element_out, '0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (list_out_if.ok !== oldest_result.ok)
          report_mismatch("ok", 32'(list_out_if.ok), 32'(oldest_result.ok));
        if (list_out_if.element_out !== oldest_result.element_out)
          report_mismatch("element_out", list_out_if.element_out, oldest_result.element_out);
        if (list_out_if.list_size !== oldest_result.list_size)
          report_mismatch("list_size", 32'(list_out_if.list_size),
                          32'(oldest_result.list_size));
        if (list_out_if.reserved !== oldest_result.reserved)
          report_mismatch("reserved", 32'(list_out_if.reserved), 32'(oldest_result.reserved));
      end
    end
  end

  // Result sink: random stalls, one long hold-off so the engine backs up
  initial begin : result_sink
    int gap;
    int drained;
    list_out_if.ready <= 1'b0;
    drained = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (drained == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        list_out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      list_out_if.ready <= 1'b1;
      do @(posedge clk); while (!list_out_if.valid);
      drained++;
    end
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Stimulus: directed table from reset, then random phases over granule settings
  initial begin : stimulus
    list_op_t                      op;
    logic [plc_pkg::GRANULE_W-1:0] phase_granule [N_PHASES];
    int                            phase_grow [N_PHASES];

    phase_granule = '{7'd127, 7'd0, 7'd64, 7'd3, 7'd62, 7'd13, 7'd1, 7'd64, 7'd1, 7'd5};
    phase_grow    = '{80, 45, 80, 55, 85, 85, 90, 20, 50, 70};

    // op {opcode, position, element}, fixed, result {ok, element, size, reserved}
    directed_rows = '{
      '{'{plc_pkg::OP_PEEK,      7'd0,   32'h0},         1'b1, '{1'b0, 32'h0, 7'd0, 7'd0}},
      '{'{plc_pkg::OP_REMOVE,    7'd0,   32'h0},         1'b1, '{1'b0, 32'h0, 7'd0, 7'd0}},
      '{'{plc_pkg::OP_EXTRACT,   7'd0,   32'h0},         1'b1, '{1'b0, 32'h0, 7'd0, 7'd0}},
      '{'{plc_pkg::OP_OVERWRITE, 7'd0,   32'hFFFF_FFFF}, 1'b1, '{1'b0, 32'h0, 7'd0, 7'd0}},
      '{'{OP_UNDEF_LO,           7'd0,   32'h0},         1'b1, '{1'b0, 32'h0, 7'd0, 7'd0}},
      '{'{OP_UNDEF_HI,           7'd127, 32'hFFFF_FFFF}, 1'b1, '{1'b0, 32'h0, 7'd0, 7'd0}},
      // insert beyond the end of an empty list
      '{'{plc_pkg::OP_INSERT,    7'd1,   32'h1234_5678}, 1'b1, '{1'b0, 32'h0, 7'd0, 7'd0}},
      // append ignores the position
      '{'{plc_pkg::OP_APPEND,    7'd127, 32'hFFFF_FFFF}, 1'b1, '{1'b1, 32'h0, 7'd1, 7'd1}},
      '{'{plc_pkg::OP_INSERT,    7'd0,   32'h0},         1'b1, '{1'b1, 32'h0, 7'd2, 7'd2}},
      '{'{plc_pkg::OP_PEEK,      7'd1,   32'h0},         1'b1,
        '{1'b1, 32'hFFFF_FFFF, 7'd2, 7'd2}},
      '{'{plc_pkg::OP_PEEK,      7'd0,   32'hFFFF_FFFF}, 1'b1, '{1'b1, 32'h0, 7'd2, 7'd2}},
      // insert exactly at the end
      '{'{plc_pkg::OP_INSERT,    7'd2,   32'hA5A5_A5A5}, 1'b0, '0},
      '{'{plc_pkg::OP_INSERT,    7'd127, 32'h0},         1'b1, '{1'b0, 32'h0, 7'd3, 7'd3}},
      '{'{plc_pkg::OP_OVERWRITE, 7'd1,   32'h5A5A_5A5A}, 1'b0, '0},
      '{'{plc_pkg::OP_OVERWRITE, 7'd3,   32'h0},         1'b1, '{1'b0, 32'h0, 7'd3, 7'd3}},
      '{'{plc_pkg::OP_PEEK,      7'd64,  32'h0},         1'b1, '{1'b0, 32'h0, 7'd3, 7'd3}},
      '{'{plc_pkg::OP_EXTRACT,   7'd0,   32'h0},         1'b0, '0},
      '{'{plc_pkg::OP_INSERT,    7'd1,   32'h8000_0001}, 1'b0, '0},
      '{'{plc_pkg::OP_REMOVE,    7'd2,   32'h0},         1'b0, '0},
      '{'{OP_UNDEF_LO,           7'd0,   32'h0},         1'b0, '0},
      '{'{plc_pkg::OP_APPEND,    7'd0,   32'h0000_0001}, 1'b0, '0},
      '{'{plc_pkg::OP_EXTRACT,   7'd2,   32'h0},         1'b0, '0}
    };

    rst_n                 <= 1'b0;
    cfg_psel              <= 1'b0;
    cfg_penable           <= 1'b0;
    cfg_pwrite            <= 1'b0;
    cfg_paddr             <= '0;
    cfg_pwdata            <= '0;
    list_in_if.valid      <= 1'b0;
    list_in_if.opcode     <= '0;
    list_in_if.position   <= '0;
    list_in_if.element_in <= '0;
    mismatch_count = 0;
    no_idle        = 1'b0;
    model_count    = 0;
    model_cap      = 0;
    model_granule  = plc_pkg::GRANULE_RESET;
    foreach (model_entries[i]) model_entries[i] = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_list_op(directed_rows[i].op, directed_rows[i].fixed, directed_rows[i].res);

    for (int p = 0; p < N_PHASES; p++) begin
      set_granule(phase_granule[p]);
      no_idle = (p % 4 == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // sender drains the engine completely once
        if (p == 4 && k == 100) begin
          list_in_if.valid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
          @(posedge clk);
        end
        op = draw_list_op(phase_grow[p]);
        send_list_op(op, 1'b0, '0);
      end
    end

    list_in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
